/* rtl/brfifo_pkg.sv */
// Shared types and constants for the circular byte FIFO with peek and unread.
`default_nettype none

package brfifo_pkg;

   localparam int BYTE_W   = 8;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int FILL_W   = 9;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 24;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_PEEK   = 2'd2,
      OP_UNREAD = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_OFFSET   = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_NOUNREAD = 3'd4,
      STAT_MISMATCH = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_LOOKUP  = 2'd1,
      S_RESOLVE = 2'd2,
      S_REPLY   = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic resolve;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/brfifo_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module brfifo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/brfifo_ctrl.sv */
// Controller state machine: sequences capture, lookup, resolve and reply.
`default_nettype none

module brfifo_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output brfifo_pkg::cmd_type     cmd
);

   import brfifo_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_RESOLVE;
         end
         S_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = S_REPLY;
         end
         S_REPLY: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/brfifo_dp.sv */
// Datapath: request registers, ring pointers, byte store and result register.
`default_nettype none

module brfifo_dp #(
   parameter int DEPTH   = 256,
   parameter int RESERVE = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire brfifo_pkg::cmd_type           cmd,
   input  wire logic [brfifo_pkg::REQ_W-1:0]  req_tdata,
   input  wire logic [brfifo_pkg::OP_W-1:0]   req_tuser,
   output logic      [brfifo_pkg::RSP_W-1:0]  rsp_tdata
);

   import brfifo_pkg::*;

   localparam int PW    = $clog2(DEPTH);
   localparam int SW    = ((PW > BYTE_W) ? PW : BYTE_W) + 1;
   localparam int LIMIT = DEPTH - RESERVE;

   typedef logic [PW-1:0] ptr_type;

   function automatic ptr_type ring_next(input ptr_type p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic ptr_type ring_prev(input ptr_type p);
      return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
   endfunction

   function automatic ptr_type ring_fill(input ptr_type wp, input ptr_type rp);
      logic [PW:0] diff;
      diff = {1'b0, wp} - {1'b0, rp};
      if (diff[PW]) begin
         diff = diff + (PW+1)'(DEPTH);
      end
      return diff[PW-1:0];
   endfunction

   op_type              op_ff;
   logic [BYTE_W-1:0]   byte_ff;
   logic [BYTE_W-1:0]   dist_ff;
   ptr_type             wp_ff, wp_in;
   ptr_type             rp_ff, rp_in;
   ptr_type             oi_ff, oi_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   status_type          status_ff, status_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                empty_ff, empty_in;

   ptr_type             rd_addr;
   logic [SW-1:0]       peek_sum;
   logic [BYTE_W-1:0]   rd_data;
   logic                wr_en;
   ptr_type             fill_now;
   ptr_type             fill_next;

   assign fill_now = ring_fill(wp_ff, rp_ff);

   // choose the slot to fetch
   always_comb begin
      peek_sum = SW'(rp_ff) + SW'(dist_ff);
      if (peek_sum >= SW'(DEPTH)) begin
         peek_sum = peek_sum - SW'(DEPTH);
      end
      case (op_ff)
         OP_PEEK:   rd_addr = peek_sum[PW-1:0];
         OP_UNREAD: rd_addr = ring_prev(rp_ff);
         default:   rd_addr = rp_ff;
      endcase
   end

   assign wr_en = cmd.resolve && (op_ff == OP_WRITE) && ((PW+1)'(fill_now) < (PW+1)'(LIMIT));

   brfifo_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (byte_ff),
      .rd_en   (cmd.lookup),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // resolve the request against current pointers and fetched byte
   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      oi_in     = oi_ff;
      data_in   = '0;
      status_in = STAT_OK;
      case (op_ff)
         OP_WRITE: begin
            if (!wr_en) begin
               status_in = STAT_FULL;
            end else begin
               wp_in = ring_next(wp_ff);
               if ((wp_in == oi_ff) && (oi_ff != rp_ff)) begin
                  oi_in = ring_next(oi_ff);
               end
            end
         end
         OP_READ: begin
            if (fill_now == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               data_in = rd_data;
               rp_in   = ring_next(rp_ff);
            end
         end
         OP_PEEK: begin
            if (fill_now == '0) begin
               status_in = STAT_EMPTY;
            end else if (SW'(dist_ff) >= SW'(fill_now)) begin
               status_in = STAT_OFFSET;
            end else begin
               data_in = rd_data;
            end
         end
         OP_UNREAD: begin
            if (oi_ff == rp_ff) begin
               status_in = STAT_NOUNREAD;
            end else if (rd_data == byte_ff) begin
               rp_in = ring_prev(rp_ff);
            end else begin
               status_in = STAT_MISMATCH;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
      fill_next = ring_fill(wp_in, rp_in);
      fill_in   = FILL_W'(fill_next);
      empty_in  = (fill_next == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         oi_ff <= '0;
      end else if (cmd.resolve) begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         oi_ff <= oi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_tuser);
         byte_ff <= req_tdata[BYTE_W-1:0];
         dist_ff <= req_tdata[2*BYTE_W-1:BYTE_W];
      end
      if (cmd.resolve) begin
         data_ff   <= data_in;
         status_ff <= status_in;
         fill_ff   <= fill_in;
         empty_ff  <= empty_in;
      end
   end

   assign rsp_tdata = {3'b000, empty_ff, fill_ff, status_ff, data_ff};

endmodule

`default_nettype wire

/* rtl/byte_ring_fifo_peek_pushback.sv */
// Top level of the circular byte FIFO with peek and unread.
//
// One request on req_ gives exactly one response on rsp_. req_tuser carries
// the operation (write, read, peek, unread); req_tdata the byte and the peek
// distance. Each response carries the byte read or peeked, a status code,
// the fill level after the request and an empty flag.
// A request is taken in the idle state, the byte store is looked up in the
// lookup state through its registered read port, the result is resolved and
// registered in the resolve state, and rsp_tvalid rises in the reply state.
// One request is in flight at a time: req_tready rises again only once the
// response has been taken from the reply register.
// While rsp_tvalid waits for rsp_tready the response holds and req_tready
// stays low. Reset clears the write, read and oldest-intact pointers, leaving
// the FIFO empty; store contents are not cleared and need no clearing pass.
// A write is refused with a full status while no more than RESERVE slots are
// free.
`default_nettype none

module byte_ring_fifo_peek_pushback #(
   parameter int DEPTH   = 256,
   parameter int RESERVE = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // data_in[7:0], offset[15:8]
   input  wire logic [1:0]  req_tuser,  // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // read_data[7:0], status[10:8],
                                        // fill_level[19:11], is_empty[20]
);

   import brfifo_pkg::*;

   cmd_type cmd;

   brfifo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   brfifo_dp #(
      .DEPTH   (DEPTH),
      .RESERVE (RESERVE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

/* test/byte_ring_fifo_peek_pushback_tb.sv */
// Self-checking testbench for the circular byte FIFO with peek and unread.
`timescale 1ns / 100ps

module byte_ring_fifo_peek_pushback_tb;
   import brfifo_pkg::*;

   localparam int RING_DEPTH   = 256;
   localparam int RING_RESERVE = 4;
   localparam int RANDOM_ITEMS = 1350;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [7:0] offset;
      logic       hold;
   } request_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] status;
      logic [8:0] fill;
      logic       is_empty;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // data_in[7:0], offset[15:8]
   logic [1:0]  req_tuser = '0;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // read_data[7:0], status[10:8],
                                  // fill_level[19:11], is_empty[20]

   byte_ring_fifo_peek_pushback #(
      .DEPTH   (RING_DEPTH),
      .RESERVE (RING_RESERVE)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   request_type  request_queue[$];
   response_type pending_responses[$];
   request_type  current_request = '0;
   int        fault_count = 0;

   // shadow of the ring
   logic [7:0] ring_bytes [0:RING_DEPTH-1];
   logic [7:0] wr_ptr = '0;
   logic [7:0] rd_ptr = '0;
   logic [7:0] intact_ptr = '0;

   task automatic apply_request(input request_type r, output response_type s);
      logic [7:0] level;
      logic [7:0] back;
      s = '0;
      s.status = STAT_OK;
      level = wr_ptr - rd_ptr;
      case (r.op)
         OP_WRITE: begin
            if (int'(level) >= RING_DEPTH - RING_RESERVE) begin
               s.status = STAT_FULL;
            end else begin
               ring_bytes[wr_ptr] = r.data;
               wr_ptr = wr_ptr + 8'd1;
               if (wr_ptr == intact_ptr && intact_ptr != rd_ptr)
                  intact_ptr = intact_ptr + 8'd1;
            end
         end
         OP_READ: begin
            if (level == 8'd0) begin
               s.status = STAT_EMPTY;
            end else begin
               s.read_data = ring_bytes[rd_ptr];
               rd_ptr = rd_ptr + 8'd1;
            end
         end
         OP_PEEK: begin
            if (level == 8'd0)
               s.status = STAT_EMPTY;
            else if (r.offset >= level)
               s.status = STAT_OFFSET;
            else
               s.read_data = ring_bytes[rd_ptr + r.offset];
         end
         default: begin
            if (intact_ptr == rd_ptr) begin
               s.status = STAT_NOUNREAD;
            end else begin
               back = rd_ptr - 8'd1;
               if (ring_bytes[back] == r.data)
                  rd_ptr = back;
               else
                  s.status = STAT_MISMATCH;
            end
         end
      endcase
      s.fill = {1'b0, wr_ptr - rd_ptr};
      s.is_empty = (wr_ptr == rd_ptr);
   endtask

   task automatic add_request(input op_type op, input logic [7:0] data,
                              input logic [7:0] offset, input logic hold);
      request_type r;
      r.op = op;
      r.data = data;
      r.offset = offset;
      r.hold = hold;
      request_queue.push_back(r);
   endtask

   task automatic add_random_request(input int w_write, input int w_read,
                                     input int w_peek, input bit narrow,
                                     input logic hold);
      int         pick;
      op_type     op;
      logic [7:0] data;
      logic [7:0] offset;
      logic [7:0] alphabet [0:3];
      alphabet[0] = 8'h00;
      alphabet[1] = 8'hFF;
      alphabet[2] = 8'h5A;
      alphabet[3] = 8'hA5;
      pick = $urandom_range(0, 99);
      if (pick < w_write)
         op = OP_WRITE;
      else if (pick < w_write + w_read)
         op = OP_READ;
      else if (pick < w_write + w_read + w_peek)
         op = OP_PEEK;
      else
         op = OP_UNREAD;
      data = narrow ? alphabet[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: offset = 8'($urandom_range(0, 3));
         1: offset = 8'($urandom_range(0, 31));
         2: offset = 8'($urandom_range(0, 255));
         default: offset = 8'($urandom_range(200, 255));
      endcase
      add_request(op, data, offset, hold);
   endtask

   initial begin
      int count;
      int seg_len;
      int mode;
      bit narrow;
      int weights [0:4][0:2];
      weights[0] = '{50, 25, 15};
      weights[1] = '{20, 40, 20};
      weights[2] = '{70, 10, 10};
      weights[3] = '{25, 25, 25};
      weights[4] = '{10, 50, 10};

      // directed: empty cases, extremes, every operation
      add_request(OP_UNREAD, 8'h00, 8'h00, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_PEEK,   8'h00, 8'h00, 1'b0);
      add_request(OP_WRITE,  8'h00, 8'h00, 1'b0);
      add_request(OP_WRITE,  8'hFF, 8'hFF, 1'b0);
      add_request(OP_WRITE,  8'hA5, 8'h00, 1'b0);
      add_request(OP_PEEK,   8'h00, 8'h00, 1'b0);
      add_request(OP_PEEK,   8'h00, 8'h02, 1'b0);
      add_request(OP_PEEK,   8'h00, 8'h03, 1'b0);
      add_request(OP_PEEK,   8'hFF, 8'hFF, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_UNREAD, 8'h01, 8'h00, 1'b0);
      add_request(OP_UNREAD, 8'h00, 8'h00, 1'b0);
      add_request(OP_UNREAD, 8'h00, 8'h00, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_UNREAD, 8'hFF, 8'h00, 1'b0);
      add_request(OP_UNREAD, 8'h00, 8'h00, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_READ,   8'h00, 8'h00, 1'b0);
      add_request(OP_PEEK,   8'h00, 8'h00, 1'b0);

      // fill past the reserve, then hold until drained
      for (count = 0; count < 330; count++)
         add_random_request(88, 4, 4, count % 2, 1'b0);
      add_random_request(0, 50, 50, 1'b0, 1'b1);
      count++;
      // drain with plenty of unread
      for (int i = 0; i < 350; i++) begin
         add_random_request(10, 45, 20, 1'b1, 1'b0);
         count++;
      end
      add_random_request(25, 25, 25, 1'b0, 1'b1);
      count++;
      while (count < RANDOM_ITEMS) begin
         seg_len = $urandom_range(30, 120);
         mode = $urandom_range(0, 4);
         narrow = $urandom_range(0, 1);
         for (int i = 0; i < seg_len; i++)
            add_random_request(weights[mode][0], weights[mode][1],
                               weights[mode][2], narrow, 1'b0);
         count += seg_len;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      response_type expected;
      logic      next_valid;
      logic      slot_free;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         slot_free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_request(current_request, expected);
            pending_responses.push_back(expected);
            slot_free = 1'b1;
            next_valid = 1'b0;
         end
         if (slot_free) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_queue.size() > 0 &&
                         !(request_queue[0].hold && pending_responses.size() > 0)) begin
               current_request <= request_queue[0];
               req_tdata <= {request_queue[0].offset, request_queue[0].data};
               req_tuser <= request_queue[0].op;
               void'(request_queue.pop_front());
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // response monitor
   int        stall_mode = 0;
   int        stall_count = 0;
   int        cycle_count = 0;
   int        report_count = 0;

   always @(posedge clock) begin
      response_type expected;
      response_type actual;
      logic      next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp_tvalid && rsp_tready) begin
            actual.read_data = rsp_tdata[7:0];
            actual.status    = rsp_tdata[10:8];
            actual.fill      = rsp_tdata[19:11];
            actual.is_empty  = rsp_tdata[20];
            if (pending_responses.size() == 0) begin
               fault_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("unexpected response %h at %0t", rsp_tdata, $realtime);
               end
            end else begin
               expected = pending_responses.pop_front();
               if (actual != expected) begin
                  fault_count++;
                  if (report_count < MAX_REPORTS) begin
                     report_count++;
                     $display("mismatch at %0t: data %h/%h status %0d/%0d fill %0d/%0d empty %b/%b",
                              $realtime, expected.read_data, actual.read_data,
                              expected.status, actual.status, expected.fill,
                              actual.fill, expected.is_empty, actual.is_empty);
                  end
               end
            end
         end
         // switch stall pattern every so often
         if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_count = $urandom_range(50, 250);
         end else begin
            stall_count--;
         end
         case (stall_mode)
            0: next_ready = 1'b1;
            1: next_ready = $urandom_range(0, 1);
            2: next_ready = (cycle_count % 5 == 0);
            default: next_ready = ($urandom_range(0, 99) < 85);
         endcase
         rsp_tready <= next_ready;
      end
   end

   initial begin
      @(negedge reset);
      @(posedge clock);
      while (request_queue.size() > 0 || req_tvalid || pending_responses.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_responses.size() == 0) begin
         $display("** byte_ring_fifo_peek_pushback: PASSED **");
      end else begin
         $display("** byte_ring_fifo_peek_pushback: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("** byte_ring_fifo_peek_pushback: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
rtl/brfifo_pkg.sv
rtl/brfifo_ram.sv
rtl/brfifo_ctrl.sv
rtl/brfifo_dp.sv
rtl/byte_ring_fifo_peek_pushback.sv
test/byte_ring_fifo_peek_pushback_tb.sv
